>>> design/spgi_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// Spiral grid index package
// Shared constants for the square spiral index to position block.
// ============================================================================
package spgi_pkg;

    localparam int MAX_SIDE_DEF = 64;

    localparam int INDEX_W   = 12;
    localparam int DIM_W     = 7;
    localparam int SPACING_W = 16;
    localparam int POS_W     = 22;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPACING_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPACING_Y = 3'd3;

    localparam logic [DIM_W-1:0]     COLUMNS_RST   = 7'd49;
    localparam logic [DIM_W-1:0]     ROWS_RST      = 7'd25;
    localparam logic [SPACING_W-1:0] SPACING_RST   = 16'd1920;

endpackage

>>> design/spiral_grid_index_to_xy.sv
`timescale 1ns / 1ps
// ============================================================================
// Spiral grid index to position
// Walks an outward square spiral one point per cycle, counts the points that
// fall inside the grid box and scales the chosen point by the spacings.
// ============================================================================
// Walk: at most side*side steps, where side is the larger clamped grid
// dimension; the walk advances one spiral point a cycle, then MULX, MULY, DONE.
// Throughput: one request at a time; a new request is taken once the walk,
// the two multiplies through the shared multiplier and the result hand-off end.
// Reset: the configuration registers return to 49 columns, 25 rows and a
// spacing of 1920 on both axes; the sequencer returns to idle.
module spiral_grid_index_to_xy
    import spgi_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [SPACING_W-1:0]        cfg_data,

    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [INDEX_W-1:0]          item_index,

    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [POS_W-1:0]     pos_x,
    output logic signed [POS_W-1:0]     pos_y,
    output logic                        found
);

    localparam int SDW  = $clog2(MAX_SIDE + 1);
    localparam int CW   = $clog2(MAX_SIDE) + 2;
    localparam int SW   = $clog2(MAX_SIDE * MAX_SIDE + 1);
    localparam int CNTW = (SW > INDEX_W) ? SW : INDEX_W;
    localparam int CMPW = (SDW > DIM_W) ? SDW : DIM_W;
    localparam int BW   = SPACING_W + 1;
    localparam int PW   = CW + BW;
    localparam int EXTW = (PW > POS_W) ? PW : POS_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_WALK  = 3'd2;
    localparam logic [2:0] ST_MULX  = 3'd3;
    localparam logic [2:0] ST_MULY  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [DIM_W-1:0]           columns_reg;
    logic [DIM_W-1:0]           rows_reg;
    logic [SPACING_W-1:0]       spacing_x_reg;
    logic [SPACING_W-1:0]       spacing_y_reg;

    logic [2:0]                 state_reg;
    logic [2:0]                 state_next;
    logic [INDEX_W-1:0]         want_reg;
    logic [SW-1:0]              steps_reg;
    logic [SW-1:0]              step_reg;
    logic [CNTW-1:0]            count_reg;
    logic signed [CW-1:0]       x_reg;
    logic signed [CW-1:0]       y_reg;
    logic signed [1:0]          dx_reg;
    logic signed [1:0]          dy_reg;
    logic                       hit_reg;
    logic signed [POS_W-1:0]    px_reg;
    logic signed [POS_W-1:0]    py_reg;

    logic                       out_valid_reg;
    logic signed [POS_W-1:0]    pos_x_reg;
    logic signed [POS_W-1:0]    pos_y_reg;
    logic                       found_reg;

    logic [SDW-1:0]             cols_side;
    logic [SDW-1:0]             rows_side;
    logic [SDW-1:0]             side;
    logic signed [CW-1:0]       hx;
    logic signed [CW-1:0]       hy;
    logic                       in_box;
    logic                       turn;
    logic                       x_neg;
    logic                       x_pos;

    logic signed [CW-1:0]       mul_a;
    logic signed [BW-1:0]       mul_b;
    logic signed [PW-1:0]       prod;
    logic signed [EXTW-1:0]     prod_ext;

    logic                       out_free;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign found     = found_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        if (CMPW'(columns_reg) > CMPW'(MAX_SIDE))
        begin
            cols_side = SDW'(MAX_SIDE);
        end
        else
        begin
            cols_side = SDW'(columns_reg);
        end
        if (CMPW'(rows_reg) > CMPW'(MAX_SIDE))
        begin
            rows_side = SDW'(MAX_SIDE);
        end
        else
        begin
            rows_side = SDW'(rows_reg);
        end
        side = (cols_side > rows_side) ? cols_side : rows_side;
        hx   = $signed(CW'(cols_side >> 1));
        hy   = $signed(CW'(rows_side >> 1));
    end

    always_comb
    begin
        x_neg  = x_reg[CW-1];
        x_pos  = !x_reg[CW-1] && (x_reg != '0);
        in_box = (x_reg >= -hx) && (x_reg <= hx) && (y_reg >= -hy) && (y_reg <= hy);
        turn   = (x_reg == y_reg)
              || (x_neg && (x_reg == -y_reg))
              || (x_pos && (x_reg == (CW'(1) - y_reg)));
    end

    // The one multiplier serves the walk length and both scaled coordinates.
    always_comb
    begin
        unique case (state_reg)
            ST_MULX:
            begin
                mul_a = x_reg;
                mul_b = $signed({1'b0, spacing_x_reg});
            end
            ST_MULY:
            begin
                mul_a = y_reg;
                mul_b = $signed({1'b0, spacing_y_reg});
            end
            default:
            begin
                mul_a = $signed(CW'(side));
                mul_b = $signed({1'b0, SPACING_W'(side)});
            end
        endcase
        prod     = mul_a * mul_b;
        prod_ext = EXTW'(prod);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if ((step_reg == steps_reg) || (in_box && (count_reg == CNTW'(want_reg))))
                begin
                    state_next = ST_MULX;
                end
            end
            ST_MULX:
            begin
                state_next = ST_MULY;
            end
            ST_MULY:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg   <= COLUMNS_RST;
            rows_reg      <= ROWS_RST;
            spacing_x_reg <= SPACING_RST;
            spacing_y_reg <= SPACING_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_COLUMNS:   columns_reg   <= cfg_data[DIM_W-1:0];
                REG_ROWS:      rows_reg      <= cfg_data[DIM_W-1:0];
                REG_SPACING_X: spacing_x_reg <= cfg_data;
                REG_SPACING_Y: spacing_y_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                want_reg  <= item_index;
                step_reg  <= '0;
                count_reg <= '0;
                x_reg     <= '0;
                y_reg     <= '0;
                dx_reg    <= 2'sd0;
                dy_reg    <= -2'sd1;
                hit_reg   <= 1'b0;
            end
            ST_SETUP:
            begin
                steps_reg <= prod_ext[SW-1:0];
            end
            ST_WALK:
            begin
                if (step_reg == steps_reg)
                begin
                    x_reg   <= '0;
                    y_reg   <= '0;
                    hit_reg <= 1'b0;
                end
                else if (in_box && (count_reg == CNTW'(want_reg)))
                begin
                    hit_reg <= 1'b1;
                end
                else
                begin
                    if (in_box)
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                    step_reg <= step_reg + 1'b1;
                    if (turn)
                    begin
                        dx_reg <= -dy_reg;
                        dy_reg <= dx_reg;
                        x_reg  <= x_reg - CW'(dy_reg);
                        y_reg  <= y_reg + CW'(dx_reg);
                    end
                    else
                    begin
                        x_reg <= x_reg + CW'(dx_reg);
                        y_reg <= y_reg + CW'(dy_reg);
                    end
                end
            end
            ST_MULX:
            begin
                px_reg <= prod_ext[POS_W-1:0];
            end
            ST_MULY:
            begin
                py_reg <= prod_ext[POS_W-1:0];
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    pos_x_reg <= px_reg;
                    pos_y_reg <= py_reg;
                    found_reg <= hit_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// Spiral grid index to position testbench
// Drives item index requests and register writes into the spiral walker and
// checks every position result against a predictor that walks the same
// spiral over shadow copies of the grid and spacing registers. A directed
// set of grids is followed by random grids, with random idling on both sides
// and one long receiver hold-off that backs up the request channel.
// ============================================================================
module testbench;
    import spgi_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam int IDLE_PCT        = 37;
    localparam int HOLD_CYCLES     = 500;
    localparam int WATCHDOG_LIMIT  = 40000;
    localparam int SETTLE_CYCLES   = 16;
    localparam int RANDOM_PHASES   = 7;
    localparam int ITEMS_PER_PHASE = 16;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic                    found;
    } point_t;

    logic                    clk        = 1'b0;
    logic                    rst_n      = 1'b0;
    logic                    cfg_valid  = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index  = '0;
    logic [SPACING_W-1:0]    cfg_data   = '0;
    logic                    in_valid   = 1'b0;
    logic                    in_ready;
    logic [INDEX_W-1:0]      item_index = '0;
    logic                    out_valid;
    logic                    out_ready  = 1'b0;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic                    found;

    logic [DIM_W-1:0]        cols_r     = COLUMNS_RST;
    logic [DIM_W-1:0]        rows_r     = ROWS_RST;
    logic [SPACING_W-1:0]    spx_r      = SPACING_RST;
    logic [SPACING_W-1:0]    spy_r      = SPACING_RST;

    logic [INDEX_W-1:0]      index_q[$];
    point_t                  point_q[$];

    logic                    in_fire    = 1'b0;
    logic                    idle_on    = 1'b1;
    logic                    hold_req   = 1'b0;
    logic                    hold_done  = 1'b0;
    int                      hold_left  = 0;
    int                      quiet_cycles = 0;
    int                      errors     = 0;

    spiral_grid_index_to_xy u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .item_index (item_index),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .found      (found)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic point_t spiral_point(input logic [INDEX_W-1:0] wanted);
        int cols, rows, hx, hy, side, steps, count, s;
        int x, y, dx, dy, t, spx, spy, prod;
        point_t pt;
        pt    = '0;
        cols  = int'(cols_r);
        rows  = int'(rows_r);
        spx   = int'(spx_r);
        spy   = int'(spy_r);
        if (cols > MAX_SIDE_DEF)
            cols = MAX_SIDE_DEF;
        if (rows > MAX_SIDE_DEF)
            rows = MAX_SIDE_DEF;
        hx    = cols / 2;
        hy    = rows / 2;
        side  = (cols > rows) ? cols : rows;
        steps = side * side;
        count = 0;
        x     = 0;
        y     = 0;
        dx    = 0;
        dy    = -1;
        s     = 0;
        while (s < steps && !pt.found)
        begin
            if (x >= -hx && x <= hx && y >= -hy && y <= hy)
            begin
                if (count == int'(wanted))
                begin
                    prod     = x * spx;
                    pt.pos_x = prod[POS_W-1:0];
                    prod     = y * spy;
                    pt.pos_y = prod[POS_W-1:0];
                    pt.found = 1'b1;
                end
                else
                begin
                    count++;
                end
            end
            if (!pt.found)
            begin
                if (x == y || (x < 0 && x == -y) || (x > 0 && x == 1 - y))
                begin
                    t  = dx;
                    dx = -dy;
                    dy = t;
                end
                x += dx;
                y += dy;
            end
            s++;
        end
        return pt;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [SPACING_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_COLUMNS:   cols_r = data[DIM_W-1:0];
            REG_ROWS:      rows_r = data[DIM_W-1:0];
            REG_SPACING_X: spx_r  = data;
            REG_SPACING_Y: spy_r  = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_grid(input logic [SPACING_W-1:0] cols,
                            input logic [SPACING_W-1:0] rows,
                            input logic [SPACING_W-1:0] spx,
                            input logic [SPACING_W-1:0] spy);
        write_reg(REG_COLUMNS, cols);
        write_reg(REG_ROWS, rows);
        write_reg(REG_SPACING_X, spx);
        write_reg(REG_SPACING_Y, spy);
    endtask

    task automatic drain;
        while (index_q.size() != 0 || in_valid || point_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Request driver: a request stays up, unchanged, until it is taken.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_fire))
        begin
            if (index_q.size() != 0 && !(idle_on && $urandom_range(0, 99) < IDLE_PCT))
            begin
                in_valid   <= 1'b1;
                item_index <= index_q.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= !idle_on || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin : observe
        point_t want;
        if (rst_n)
        begin
            in_fire <= in_valid && in_ready;
            if (in_valid && in_ready)
                point_q.push_back(spiral_point(item_index));
            if (out_valid && out_ready)
            begin
                if (point_q.size() == 0)
                begin
                    report_mismatch("result with no request outstanding");
                end
                else
                begin
                    want = point_q.pop_front();
                    if (pos_x !== want.pos_x)
                        report_mismatch($sformatf("pos_x got %0d want %0d",
                                                  pos_x, want.pos_x));
                    if (pos_y !== want.pos_y)
                        report_mismatch($sformatf("pos_y got %0d want %0d",
                                                  pos_y, want.pos_y));
                    if (found !== want.found)
                        report_mismatch($sformatf("found got %b want %b",
                                                  found, want.found));
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("testbench failed");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin : stimulus
        int ph, k, c, r, ca, ra, n_box;
        logic [SPACING_W-1:0] cdat, rdat;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset grid: first turns, last point in the box, one past it, extremes.
        for (k = 0; k < 10; k++)
            index_q.push_back(INDEX_W'(k));
        index_q.push_back(12'd24);
        index_q.push_back(12'd1224);
        index_q.push_back(12'd1225);
        index_q.push_back(12'hFFF);
        index_q.push_back(12'hAAA);
        index_q.push_back(12'h555);
        drain;

        // Empty grid: the walk has no steps at all.
        set_grid(16'd0, 16'd0, SPACING_RST, SPACING_RST);
        index_q.push_back(12'd0);
        index_q.push_back(12'd1);
        drain;

        // Zero width: only x = 0 is admitted; upper data bits must be dropped.
        set_grid(16'hFF80, 16'hFF85, 16'd256, 16'd384);
        index_q.push_back(12'd0);
        index_q.push_back(12'd2);
        index_q.push_back(12'd4);
        index_q.push_back(12'd5);
        drain;

        // Oversized grid saturates, largest spacings give the largest products.
        set_grid(16'd127, 16'd64, 16'hFFFF, 16'hFFFF);
        index_q.push_back(12'hFFF);
        index_q.push_back(12'd0);
        index_q.push_back(12'd4);
        index_q.push_back(12'd100);
        drain;

        // Writes to indexes outside the register map must leave it unchanged.
        write_reg(REG_SPARE_LO, 16'd0);
        write_reg(REG_SPARE_HI, 16'd0);
        index_q.push_back(12'd1);
        index_q.push_back(12'd2);
        drain;

        set_grid(16'd1, 16'd64, 16'd0, 16'd1);
        index_q.push_back(12'd0);
        index_q.push_back(12'd10);
        drain;

        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            c  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 20);
            r  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 20);
            cdat = SPACING_W'($urandom());
            rdat = SPACING_W'($urandom());
            cdat[DIM_W-1:0] = DIM_W'(c);
            rdat[DIM_W-1:0] = DIM_W'(r);
            set_grid(cdat, rdat, SPACING_W'($urandom_range(0, 65535)),
                     SPACING_W'($urandom_range(0, 65535)));
            ca    = (c > MAX_SIDE_DEF) ? MAX_SIDE_DEF : c;
            ra    = (r > MAX_SIDE_DEF) ? MAX_SIDE_DEF : r;
            n_box = ((ca / 2) * 2 + 1) * ((ra / 2) * 2 + 1);
            idle_on = (ph != 2);
            for (k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if ($urandom_range(0, 4) == 0)
                    index_q.push_back(INDEX_W'($urandom_range(0, 4095)));
                else
                    index_q.push_back(INDEX_W'($urandom_range(0, n_box)));
            end
            if (ph == 0)
                hold_req = 1'b1;
            drain;
        end

        if (point_q.size() != 0)
            report_mismatch("requests left without a result");
        if (errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

>>> sim.f
design/spgi_pkg.sv
design/spiral_grid_index_to_xy.sv
tb/sv/testbench.sv
